/* sv/icl_pkg.sv */
// icl_pkg: constants, codes and shared types of the indexed colour map lookup
// no dependencies; imported by the divider and the top level
`timescale 1ns / 1ps

package icl_pkg;

  localparam int NUM_STOPS     = 8;
  localparam int STOP_AW       = $clog2(NUM_STOPS);
  localparam int NUM_OVR       = 16;
  localparam int OVR_AW        = $clog2(NUM_OVR);
  localparam int GAMMA_ENTRIES = 1024;
  localparam int GAMMA_AW      = $clog2(GAMMA_ENTRIES);
  localparam int FRAC_BITS     = 16;

  localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // item modes
  localparam logic [2:0] MODE_LOOKUP  = 3'd0;
  localparam logic [2:0] MODE_STOP    = 3'd1;
  localparam logic [2:0] MODE_OVR_SET = 3'd2;
  localparam logic [2:0] MODE_OVR_DEL = 3'd3;
  localparam logic [2:0] MODE_GAMMA   = 3'd4;

  // result status
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADARG = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_START   = 3'd0;
  localparam logic [2:0] REG_END     = 3'd1;
  localparam logic [2:0] REG_SRGB    = 3'd2;
  localparam logic [2:0] REG_ERGB    = 3'd3;
  localparam logic [2:0] REG_MONO    = 3'd4;
  localparam logic [2:0] REG_NSTOPS  = 3'd5;
  localparam logic [2:0] REG_GAMMA   = 3'd6;
  localparam logic [2:0] REG_MARKERS = 3'd7;

  localparam logic [23:0] RGB_BLUE  = 24'h0000FF;
  localparam logic [23:0] RGB_RED   = 24'hFF0000;
  localparam logic [23:0] RGB_WHITE = 24'hFFFFFF;

  typedef struct packed {
    logic               start;
    logic signed [19:0] num;
    logic signed [19:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [FRAC_BITS:0] quot;
  } div_rsp_t;

endpackage

/* sv/icl_ifs.sv */
// icl_in_if / icl_out_if: valid-ready channels of the colour map lookup
// no dependencies
`timescale 1ns / 1ps

interface icl_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [16:0] index;
  logic [9:0]         table_address;
  logic [15:0]        fraction;
  logic [7:0]         color_red;
  logic [7:0]         color_green;
  logic [7:0]         color_blue;

  modport source (output valid, mode, index, table_address, fraction, color_red,
                  color_green, color_blue, input ready);
  modport sink (input valid, mode, index, table_address, fraction, color_red,
                color_green, color_blue, output ready);
endinterface

interface icl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [1:0] status;

  modport source (output valid, red_out, green_out, blue_out, status, input ready);
  modport sink (input valid, red_out, green_out, blue_out, status, output ready);
endinterface

/* sv/icl_div.sv */
// icl_div: ratio unit, num/den clipped to [0,1] in unsigned Q1.16, one bit a cycle
// depends on icl_pkg
`timescale 1ns / 1ps

module icl_div import icl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic               busy_q, done_q;
  logic [4:0]         cnt_q;
  logic [19:0]        rem_q, den_q;
  logic [FRAC_BITS:0] quot_q;
  logic signed [19:0] nn, dd;
  logic [20:0]        r2, diff;
  logic               ge;

  always_comb begin
    if (req_i.den < 0) begin
      nn = -req_i.num;
      dd = -req_i.den;
    end else begin
      nn = req_i.num;
      dd = req_i.den;
    end
    r2   = {rem_q, 1'b0};
    ge   = r2 >= {1'b0, den_q};
    diff = r2 - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        if (dd == 0) begin
          quot_q <= (nn > 0) ? FRAC_ONE : '0;
          done_q <= 1'b1;
        end else if (nn <= 0) begin
          quot_q <= '0;
          done_q <= 1'b1;
        end else if (nn >= dd) begin
          quot_q <= FRAC_ONE;
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          rem_q  <= nn;
          den_q  <= dd;
          quot_q <= '0;
          cnt_q  <= 5'(FRAC_BITS);
        end
      end else if (busy_q) begin
        rem_q  <= ge ? diff[19:0] : r2[19:0];
        quot_q <= {quot_q[FRAC_BITS-1:0], ge};
        cnt_q  <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

/* sv/indexed_colormap_lookup.sv */
// indexed_colormap_lookup: maps a signed index to rgb through stops, overrides, gamma
// depends on icl_pkg, icl_ifs (channels) and icl_div (ratio unit)
//
//   channel   dir   beat payload
//   in_ch     in    mode, index, table_address, fraction, colour
//   out_ch    out   red_out, green_out, blue_out, status
//   cfg       in    cfg_we_i, cfg_index_i, cfg_data_i (write only)
//
// one item at a time; from one accepted beat to the next, a lookup that reaches the
// blend runs through prep and marker check, override scan, the serial ratio unit (once
// when no stop is in use, else twice; short when the ratio is trivial), gamma when on,
// stop walk and bounds, blend on the shared multiplier, result load and idle; a marker
// hit or an override hit goes straight to the result load
// table writes go from prep to the result load; override set and remove run the scan
// the result sits in an output register so the next beat is taken while it waits
// reset sets the registers to defaults and clears the override valid bits; the gamma
// read register and the other stores are undefined until written
`timescale 1ns / 1ps

module indexed_colormap_lookup import icl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  icl_in_if.sink      in_ch,
  icl_out_if.source   out_ch,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_PREP  = 5'd1;
  localparam logic [4:0] S_MARK  = 5'd2;
  localparam logic [4:0] S_OSCAN = 5'd3;
  localparam logic [4:0] S_DIV   = 5'd4;
  localparam logic [4:0] S_GMUL  = 5'd5;
  localparam logic [4:0] S_GRD   = 5'd6;
  localparam logic [4:0] S_GMUL2 = 5'd7;
  localparam logic [4:0] S_GIDX  = 5'd8;
  localparam logic [4:0] S_SEEK  = 5'd9;
  localparam logic [4:0] S_LBMUL = 5'd10;
  localparam logic [4:0] S_LB    = 5'd11;
  localparam logic [4:0] S_UBMUL = 5'd12;
  localparam logic [4:0] S_UB    = 5'd13;
  localparam logic [4:0] S_BLMUL = 5'd14;
  localparam logic [4:0] S_BLADD = 5'd15;
  localparam logic [4:0] S_DONE  = 5'd16;

  // configuration
  logic signed [16:0] start_q, end_q;
  logic [23:0]        srgb_q, ergb_q, mono_q;
  logic [3:0]         nstops_q;
  logic               gamma_on_q, markers_q;

  // item and work registers
  logic [4:0]         state_q;
  logic [2:0]         mode_q;
  logic [16:0]        key_q;
  logic [9:0]         addr_q;
  logic [15:0]        frac_q;
  logic [23:0]        col_q;
  logic signed [16:0] idx_q;
  logic [FRAC_BITS:0] lam_q;
  logic [3:0]         ptr_q, k_q;
  logic               free_found_q;
  logic [OVR_AW-1:0]  free_slot_q;
  logic signed [19:0] lb_q;
  logic [23:0]        c1_q, c2_q, rgb_q;
  logic [1:0]         ch_q, status_q;
  logic signed [37:0] prod_q;
  logic               seg_q, div_go_q;
  logic signed [19:0] num_q, den_q;
  logic [15:0]        gdata_q;

  logic               out_valid_q;
  logic [23:0]        out_rgb_q;
  logic [1:0]         out_status_q;

  // stores
  logic [15:0]        stop_pos_q [NUM_STOPS];
  logic [23:0]        stop_col_q [NUM_STOPS];
  logic [16:0]        ovr_key_q  [NUM_OVR];
  logic [23:0]        ovr_col_q  [NUM_OVR];
  logic [NUM_OVR-1:0] ovr_valid_q;
  logic [15:0]        gmem       [GAMMA_ENTRIES];

  div_req_t div_req;
  div_rsp_t div_rsp;

  icl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign div_req.start = div_go_q;
  assign div_req.num   = num_q;
  assign div_req.den   = den_q;

  // derived range
  logic signed [16:0] e_w, clamp_w;
  logic [17:0]        d_w;
  logic [3:0]         n_w;
  logic [STOP_AW-1:0] sp;
  logic [OVR_AW-1:0]  op;
  logic               ohit;

  always_comb begin
    e_w = (end_q < start_q) ? start_q : end_q;
    d_w = 18'({e_w[16], e_w} - {start_q[16], start_q});
    if ($signed(key_q) < start_q) clamp_w = start_q;
    else if ($signed(key_q) > e_w) clamp_w = e_w;
    else clamp_w = $signed(key_q);
    n_w  = (nstops_q > 4'(NUM_STOPS)) ? 4'(NUM_STOPS) : nstops_q;
    sp   = ptr_q[STOP_AW-1:0];
    op   = ptr_q[OVR_AW-1:0];
    ohit = ovr_valid_q[op] && (ovr_key_q[op] == key_q);
  end

  // shared multiplier
  logic signed [18:0] mul_a, mul_b;
  logic signed [37:0] mul_p;
  logic [7:0]         ca, cb;
  logic signed [8:0]  cdiff;

  always_comb begin
    case (ch_q)
      2'd0:    begin ca = c1_q[7:0];   cb = c2_q[7:0];   end
      2'd1:    begin ca = c1_q[15:8];  cb = c2_q[15:8];  end
      default: begin ca = c1_q[23:16]; cb = c2_q[23:16]; end
    endcase
    cdiff = $signed({1'b0, cb}) - $signed({1'b0, ca});
    case (state_q)
      S_GMUL:  begin mul_a = $signed({2'b0, lam_q}); mul_b = 19'sd1023; end
      S_GMUL2: begin mul_a = $signed({3'b0, gdata_q}); mul_b = $signed({1'b0, d_w}); end
      S_LBMUL, S_UBMUL: begin
        mul_a = $signed({3'b0, stop_pos_q[sp]});
        mul_b = $signed({1'b0, d_w});
      end
      default: begin mul_a = {{10{cdiff[8]}}, cdiff}; mul_b = $signed({2'b0, lam_q}); end
    endcase
    mul_p = mul_a * mul_b;
  end

  // stop index bound, gamma index and blend tails
  logic [37:0]        rnd_w;
  logic signed [19:0] bnd_w;
  logic signed [37:0] gsum_w;
  logic signed [16:0] gidx_w;
  logic signed [37:0] bsum_w;
  logic [23:0]        mono_c1, mono_c2;

  always_comb begin
    rnd_w  = prod_q + 38'sd32768;
    bnd_w  = {{3{start_q[16]}}, start_q} + $signed({2'b0, rnd_w[33:16]});
    gsum_w = ({{21{start_q[16]}}, start_q} <<< FRAC_BITS) + prod_q;
    if (gsum_w < 0 && gsum_w[FRAC_BITS-1:0] != '0)
      gidx_w = 17'(gsum_w >>> FRAC_BITS) + 17'sd1;
    else
      gidx_w = 17'(gsum_w >>> FRAC_BITS);
    bsum_w = $signed({14'b0, ca, 16'b0}) + prod_q;
    if (srgb_q == 24'd0 && ergb_q == RGB_WHITE) begin
      mono_c1 = 24'd0;
      mono_c2 = mono_q;
    end else begin
      mono_c1 = srgb_q;
      mono_c2 = ergb_q;
    end
  end

  assign in_ch.ready = (state_q == S_IDLE);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= '0;
      end_q      <= 17'sd65535;
      srgb_q     <= '0;
      ergb_q     <= RGB_WHITE;
      mono_q     <= RGB_WHITE;
      nstops_q   <= '0;
      gamma_on_q <= 1'b0;
      markers_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_START:   start_q    <= $signed(cfg_data_i[16:0]);
        REG_END:     end_q      <= $signed(cfg_data_i[16:0]);
        REG_SRGB:    srgb_q     <= cfg_data_i;
        REG_ERGB:    ergb_q     <= cfg_data_i;
        REG_MONO:    mono_q     <= cfg_data_i;
        REG_NSTOPS:  nstops_q   <= cfg_data_i[3:0];
        REG_GAMMA:   gamma_on_q <= cfg_data_i[0];
        REG_MARKERS: markers_q  <= cfg_data_i[0];
        default:     ;
      endcase
    end
  end

  // gamma memory, registered read
  always_ff @(posedge clk_i) begin
    if (state_q == S_PREP && mode_q == MODE_GAMMA)
      gmem[addr_q[GAMMA_AW-1:0]] <= frac_q;
    if (state_q == S_GRD)
      gdata_q <= gmem[prod_q[FRAC_BITS+GAMMA_AW-1:FRAC_BITS]];
  end

  // stop and override stores
  always_ff @(posedge clk_i) begin
    if (state_q == S_PREP && mode_q == MODE_STOP && addr_q < 10'(NUM_STOPS) &&
        frac_q != 16'd0) begin
      stop_pos_q[addr_q[STOP_AW-1:0]] <= frac_q;
      stop_col_q[addr_q[STOP_AW-1:0]] <= col_q;
    end
    if (state_q == S_OSCAN && mode_q == MODE_OVR_SET) begin
      if (ohit) begin
        ovr_col_q[op] <= col_q;
      end else if (ptr_q == 4'(NUM_OVR - 1)) begin
        if (free_found_q) begin
          ovr_key_q[free_slot_q] <= key_q;
          ovr_col_q[free_slot_q] <= col_q;
        end else if (!ovr_valid_q[op]) begin
          ovr_key_q[op] <= key_q;
          ovr_col_q[op] <= col_q;
        end
      end
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ovr_valid_q  <= '0;
      out_valid_q  <= 1'b0;
      div_go_q     <= 1'b0;
      mode_q       <= '0;
      key_q        <= '0;
      addr_q       <= '0;
      frac_q       <= '0;
      col_q        <= '0;
      idx_q        <= '0;
      lam_q        <= '0;
      ptr_q        <= '0;
      k_q          <= '0;
      free_found_q <= 1'b0;
      free_slot_q  <= '0;
      lb_q         <= '0;
      c1_q         <= '0;
      c2_q         <= '0;
      rgb_q        <= '0;
      ch_q         <= '0;
      status_q     <= ST_OK;
      prod_q       <= '0;
      seg_q        <= 1'b0;
      num_q        <= '0;
      den_q        <= '0;
      out_rgb_q    <= '0;
      out_status_q <= ST_OK;
    end else begin
      div_go_q <= 1'b0;
      if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_ch.valid) begin
            mode_q  <= in_ch.mode;
            key_q   <= in_ch.index;
            addr_q  <= in_ch.table_address;
            frac_q  <= in_ch.fraction;
            col_q   <= {in_ch.color_red, in_ch.color_green, in_ch.color_blue};
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          status_q     <= ST_OK;
          rgb_q        <= '0;
          ptr_q        <= '0;
          free_found_q <= 1'b0;
          case (mode_q)
            MODE_LOOKUP: begin
              key_q   <= clamp_w;
              idx_q   <= clamp_w;
              state_q <= S_MARK;
            end
            MODE_STOP: begin
              if (addr_q >= 10'(NUM_STOPS) || frac_q == 16'd0) status_q <= ST_BADARG;
              state_q <= S_DONE;
            end
            MODE_OVR_SET, MODE_OVR_DEL: state_q <= S_OSCAN;
            MODE_GAMMA: state_q <= S_DONE;
            default: begin
              status_q <= ST_BADARG;
              state_q  <= S_DONE;
            end
          endcase
        end
        S_MARK: begin
          if (markers_q && idx_q == start_q) begin
            rgb_q   <= RGB_BLUE;
            state_q <= S_DONE;
          end else if (markers_q && idx_q == e_w) begin
            rgb_q   <= RGB_RED;
            state_q <= S_DONE;
          end else begin
            state_q <= S_OSCAN;
          end
        end
        S_OSCAN: begin
          if (!ovr_valid_q[op] && !free_found_q) begin
            free_found_q <= 1'b1;
            free_slot_q  <= op;
          end
          if (ohit && mode_q == MODE_LOOKUP) begin
            rgb_q   <= ovr_col_q[op];
            state_q <= S_DONE;
          end else if (ohit && mode_q == MODE_OVR_SET) begin
            state_q <= S_DONE;
          end else begin
            if (ohit) ovr_valid_q[op] <= 1'b0;
            if (ptr_q == 4'(NUM_OVR - 1)) begin
              case (mode_q)
                MODE_LOOKUP: begin
                  num_q    <= {{3{idx_q[16]}}, idx_q} - {{3{start_q[16]}}, start_q};
                  den_q    <= $signed({2'b0, d_w});
                  seg_q    <= 1'b0;
                  div_go_q <= 1'b1;
                  state_q  <= S_DIV;
                end
                MODE_OVR_SET: begin
                  if (free_found_q) ovr_valid_q[free_slot_q] <= 1'b1;
                  else if (!ovr_valid_q[op]) ovr_valid_q[op] <= 1'b1;
                  else status_q <= ST_FULL;
                  state_q <= S_DONE;
                end
                default: state_q <= S_DONE;
              endcase
            end else begin
              ptr_q <= ptr_q + 4'd1;
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            lam_q <= div_rsp.quot;
            ch_q  <= '0;
            ptr_q <= '0;
            if (seg_q) state_q <= S_BLMUL;
            else if (gamma_on_q) state_q <= S_GMUL;
            else if (n_w == 4'd0) begin
              c1_q    <= mono_c1;
              c2_q    <= mono_c2;
              state_q <= S_BLMUL;
            end else state_q <= S_SEEK;
          end
        end
        S_GMUL: begin
          prod_q  <= mul_p;
          state_q <= S_GRD;
        end
        S_GRD: state_q <= S_GMUL2;
        S_GMUL2: begin
          lam_q   <= {1'b0, gdata_q};
          prod_q  <= mul_p;
          state_q <= S_GIDX;
        end
        S_GIDX: begin
          idx_q <= gidx_w;
          ptr_q <= '0;
          if (n_w == 4'd0) begin
            c1_q    <= mono_c1;
            c2_q    <= mono_c2;
            state_q <= S_BLMUL;
          end else state_q <= S_SEEK;
        end
        S_SEEK: begin
          if ({1'b0, stop_pos_q[sp]} >= lam_q || ptr_q == n_w - 4'd1) begin
            if ({1'b0, stop_pos_q[sp]} >= lam_q) k_q <= ptr_q;
            else k_q <= n_w;
            if ({1'b0, stop_pos_q[sp]} >= lam_q && ptr_q == 4'd0) begin
              lb_q    <= {{3{start_q[16]}}, start_q};
              state_q <= S_UBMUL;
            end else if ({1'b0, stop_pos_q[sp]} >= lam_q) begin
              ptr_q   <= ptr_q - 4'd1;
              state_q <= S_LBMUL;
            end else begin
              state_q <= S_LBMUL;
            end
          end else begin
            ptr_q <= ptr_q + 4'd1;
          end
        end
        S_LBMUL: begin
          prod_q  <= mul_p;
          c1_q    <= stop_col_q[sp];
          state_q <= S_LB;
        end
        S_LB: begin
          lb_q <= bnd_w;
          if (k_q == n_w) begin
            num_q    <= {{3{idx_q[16]}}, idx_q} - bnd_w;
            den_q    <= {{3{e_w[16]}}, e_w} - bnd_w;
            c2_q     <= ergb_q;
            seg_q    <= 1'b1;
            div_go_q <= 1'b1;
            state_q  <= S_DIV;
          end else begin
            ptr_q   <= k_q;
            state_q <= S_UBMUL;
          end
        end
        S_UBMUL: begin
          prod_q <= mul_p;
          c2_q   <= stop_col_q[sp];
          if (k_q == 4'd0) c1_q <= srgb_q;
          state_q <= S_UB;
        end
        S_UB: begin
          num_q    <= {{3{idx_q[16]}}, idx_q} - lb_q;
          den_q    <= bnd_w - lb_q;
          seg_q    <= 1'b1;
          div_go_q <= 1'b1;
          state_q  <= S_DIV;
        end
        S_BLMUL: begin
          prod_q  <= mul_p;
          state_q <= S_BLADD;
        end
        S_BLADD: begin
          case (ch_q)
            2'd0:    rgb_q[7:0]   <= bsum_w[23:16];
            2'd1:    rgb_q[15:8]  <= bsum_w[23:16];
            default: rgb_q[23:16] <= bsum_w[23:16];
          endcase
          if (ch_q == 2'd2) state_q <= S_DONE;
          else begin
            ch_q    <= ch_q + 2'd1;
            state_q <= S_BLMUL;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ch.ready) begin
            out_valid_q  <= 1'b1;
            out_rgb_q    <= rgb_q;
            out_status_q <= status_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.red_out   = out_rgb_q[23:16];
  assign out_ch.green_out = out_rgb_q[15:8];
  assign out_ch.blue_out  = out_rgb_q[7:0];
  assign out_ch.status    = out_status_q;

endmodule

/* bench/tb_indexed_colormap_lookup.sv */
// tb_indexed_colormap_lookup: self-checking bench for the indexed colour map lookup
// depends on icl_pkg, the icl_in_if / icl_out_if channels and indexed_colormap_lookup
`timescale 1ns / 1ps

module tb_indexed_colormap_lookup;
  import icl_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int NUM_PHASES = 8;
  localparam int POOL_SIZE = 24;
  localparam logic [2:0] MODE_SPARE = MODE_GAMMA + 3'd1;
  localparam logic [2:0] MODE_TOP = '1;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [16:0] index;
    logic [9:0]         addr;
    logic [15:0]        frac;
    logic [23:0]        rgb;
  } lut_cmd_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [1:0] st;
  } pixel_t;

  typedef struct packed {
    lut_cmd_t cmd;
    logic     typed;
    pixel_t   want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_index_i;
  logic [23:0] cfg_data_i;

  icl_in_if in_ch ();
  icl_out_if out_ch ();

  indexed_colormap_lookup u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the block's registers and stores
  logic signed [16:0] range_lo, range_hi;
  logic [23:0] colour_lo, colour_hi, tint;
  logic [3:0]  stop_cnt;
  logic        gamma_en, marker_en;
  logic [15:0] knot_pos [NUM_STOPS];
  logic [23:0] knot_rgb [NUM_STOPS];
  bit          knot_set [NUM_STOPS];
  logic [16:0] pin_key [NUM_OVR];
  logic [23:0] pin_rgb [NUM_OVR];
  bit          pin_live [NUM_OVR];
  logic [15:0] curve [GAMMA_ENTRIES];
  bit          curve_set [GAMMA_ENTRIES];

  // set when a lookup would read a store entry that was never written
  bit          needs_fill;
  bit          fill_gamma;
  int          fill_addr;

  pixel_t      pending_px [$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_now = 1'b0;
  logic [16:0] key_pool [POOL_SIZE];
  row_t        plan [20];

  function automatic longint seg_ratio(longint num, longint den);
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (den == 0) return (num > 0) ? 65536 : 0;
    if (num <= 0) return 0;
    if (num >= den) return 65536;
    return (num << FRAC_BITS) / den;
  endfunction

  function automatic longint knot_index(int k, longint s, longint d);
    if (!knot_set[k]) begin
      needs_fill = 1'b1;
      fill_gamma = 1'b0;
      fill_addr = k;
    end
    return s + ((longint'(knot_pos[k]) * d + 32768) >>> FRAC_BITS);
  endfunction

  function automatic logic [23:0] mix(logic [23:0] c1, logic [23:0] c2, longint lam);
    logic [23:0] res;
    longint v;
    res = '0;
    for (int sh = 0; sh <= 16; sh += 8) begin
      v = (longint'(c1[sh +: 8]) * (65536 - lam) + longint'(c2[sh +: 8]) * lam) >>> FRAC_BITS;
      res[sh +: 8] = v[7:0];
    end
    return res;
  endfunction

  function automatic logic [23:0] map_index(longint idx);
    longint s, e, d, lam, lb, ub;
    int n, k, a;
    logic [23:0] c1, c2;
    s = longint'(range_lo);
    e = longint'(range_hi);
    if (e < s) e = s;
    d = e - s;
    if (idx < s) idx = s;
    if (idx > e) idx = e;
    if (marker_en) begin
      if (idx == s) return RGB_BLUE;
      if (idx == e) return RGB_RED;
    end
    for (int i = 0; i < NUM_OVR; i++)
      if (pin_live[i] && pin_key[i] == idx[16:0]) return pin_rgb[i];
    lam = seg_ratio(idx - s, d);
    if (gamma_en) begin
      a = int'((lam * (GAMMA_ENTRIES - 1)) >>> FRAC_BITS);
      if (a >= GAMMA_ENTRIES) a = GAMMA_ENTRIES - 1;
      if (!curve_set[a]) begin
        needs_fill = 1'b1;
        fill_gamma = 1'b1;
        fill_addr = a;
      end
      lam = longint'(curve[a]);
      idx = (s * 65536 + lam * d) / 65536;
    end
    n = (stop_cnt > NUM_STOPS) ? NUM_STOPS : int'(stop_cnt);
    if (n == 0) begin
      c1 = colour_lo;
      c2 = colour_hi;
      if (colour_lo == 24'h0 && colour_hi == RGB_WHITE) c2 = tint;
    end else begin
      k = n;
      for (int i = 0; i < n; i++) begin
        if (!knot_set[i]) begin
          needs_fill = 1'b1;
          fill_gamma = 1'b0;
          fill_addr = i;
        end
        if (longint'(knot_pos[i]) >= lam) begin
          k = i;
          break;
        end
      end
      if (k == 0) begin
        ub = knot_index(0, s, d);
        lam = seg_ratio(idx - s, ub - s);
        c1 = colour_lo;
        c2 = knot_rgb[0];
      end else if (k == n) begin
        lb = knot_index(k - 1, s, d);
        lam = seg_ratio(idx - lb, e - lb);
        c1 = knot_rgb[k - 1];
        c2 = colour_hi;
      end else begin
        lb = knot_index(k - 1, s, d);
        ub = knot_index(k, s, d);
        lam = seg_ratio(idx - lb, ub - lb);
        c1 = knot_rgb[k - 1];
        c2 = knot_rgb[k];
      end
    end
    return mix(c1, c2, lam);
  endfunction

  // advances the shadow state by one beat and returns the colour it maps to
  function automatic pixel_t apply_cmd(lut_cmd_t c);
    pixel_t p;
    logic [23:0] rgb;
    int slot;
    rgb = '0;
    p.st = ST_OK;
    slot = -1;
    case (c.mode)
      MODE_LOOKUP: rgb = map_index(longint'(c.index));
      MODE_STOP: begin
        if (c.addr >= NUM_STOPS || c.frac == 16'h0) p.st = ST_BADARG;
        else begin
          knot_pos[c.addr] = c.frac;
          knot_rgb[c.addr] = c.rgb;
          knot_set[c.addr] = 1'b1;
        end
      end
      MODE_OVR_SET: begin
        for (int i = 0; i < NUM_OVR; i++)
          if (slot < 0 && pin_live[i] && pin_key[i] == c.index) slot = i;
        for (int i = 0; i < NUM_OVR; i++)
          if (slot < 0 && !pin_live[i]) slot = i;
        if (slot < 0) p.st = ST_FULL;
        else begin
          pin_key[slot] = c.index;
          pin_rgb[slot] = c.rgb;
          pin_live[slot] = 1'b1;
        end
      end
      MODE_OVR_DEL: begin
        for (int i = 0; i < NUM_OVR; i++)
          if (pin_live[i] && pin_key[i] == c.index) pin_live[i] = 1'b0;
      end
      MODE_GAMMA: begin
        curve[c.addr] = c.frac;
        curve_set[c.addr] = 1'b1;
      end
      default: p.st = ST_BADARG;
    endcase
    p.r = rgb[23:16];
    p.g = rgb[15:8];
    p.b = rgb[7:0];
    return p;
  endfunction

  function automatic row_t row(logic [2:0] m, int idx, int adr, int fr, logic [23:0] col,
                               bit typed, logic [23:0] wrgb, logic [1:0] wst);
    row_t t;
    t.cmd = '{mode: m, index: idx[16:0], addr: adr[9:0], frac: fr[15:0], rgb: col};
    t.typed = typed;
    t.want = '{r: wrgb[23:16], g: wrgb[15:8], b: wrgb[7:0], st: wst};
    return t;
  endfunction

  task automatic report_bad(string what, logic [7:0] got, logic [7:0] want);
    $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // result side
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_px.size() == 0) report_bad("unexpected beat, red", out_ch.red_out, 8'h0);
      else begin
        want = pending_px.pop_front();
        if (out_ch.red_out !== want.r) report_bad("red", out_ch.red_out, want.r);
        if (out_ch.green_out !== want.g) report_bad("green", out_ch.green_out, want.g);
        if (out_ch.blue_out !== want.b) report_bad("blue", out_ch.blue_out, want.b);
        if (out_ch.status !== want.st) report_bad("status", 8'(out_ch.status), 8'(want.st));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_now) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_now = 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  task automatic push_item(lut_cmd_t c, bit typed, pixel_t want);
    pixel_t p;
    in_ch.valid <= 1'b1;
    in_ch.mode <= c.mode;
    in_ch.index <= c.index;
    in_ch.table_address <= c.addr;
    in_ch.fraction <= c.frac;
    in_ch.color_red <= c.rgb[23:16];
    in_ch.color_green <= c.rgb[15:8];
    in_ch.color_blue <= c.rgb[7:0];
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    p = apply_cmd(c);
    pending_px.push_back(typed ? want : p);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_regs(logic signed [16:0] lo, logic signed [16:0] hi,
                            logic [23:0] c_lo, logic [23:0] c_hi, logic [23:0] mono,
                            logic [3:0] n, logic g_en, logic m_en);
    logic [23:0] vals [8];
    logic [2:0] regs [8];
    regs = '{REG_START, REG_END, REG_SRGB, REG_ERGB, REG_MONO, REG_NSTOPS, REG_GAMMA,
             REG_MARKERS};
    vals = '{24'(lo[16:0]), 24'(hi[16:0]), c_lo, c_hi, mono, 24'(n), 24'(g_en), 24'(m_en)};
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    range_lo = lo;
    range_hi = hi;
    colour_lo = c_lo;
    colour_hi = c_hi;
    tint = mono;
    stop_cnt = n;
    gamma_en = g_en;
    marker_en = m_en;
  endtask

  task automatic configure(int ph);
    int w, lo, hi, top;
    logic [23:0] c_lo, c_hi;
    logic [3:0] n;
    w = 0;
    while (w < NUM_STOPS && knot_set[w]) w++;
    n = 4'($urandom_range(0, w));
    if (w == NUM_STOPS && $urandom_range(0, 1)) n = 4'($urandom_range(NUM_STOPS, 15));
    lo = $urandom_range(0, 131071) - 65536;
    hi = lo + $urandom_range(1, 65535 - lo > 4000 ? 4000 : 65535 - lo);
    top = lo + $urandom_range(1, 300);
    if (top > 65535) top = 65535;
    c_lo = 24'($urandom);
    c_hi = 24'($urandom);
    case (ph)
      0: write_regs(17'sd0, 17'sd65535, 24'h0, RGB_WHITE, RGB_WHITE, 4'd0, 1'b0, 1'b0);
      1: write_regs(17'h10000, 17'sd65535, c_lo, c_hi, 24'($urandom), n, 1'($urandom), 1'b1);
      2: write_regs(17'(lo), 17'(lo), c_lo, c_hi, 24'($urandom), n, 1'($urandom), 1'b1);
      3: write_regs(17'(hi > 65535 ? 65535 : hi), 17'(lo), c_lo, RGB_WHITE, 24'h0, n, 1'b0,
                    1'b1);
      4: write_regs(17'(lo), 17'(top), 24'h0, RGB_WHITE, 24'($urandom), 4'd0, 1'($urandom),
                    1'($urandom));
      5: write_regs(17'(lo), 17'(hi), RGB_WHITE, 24'h0, RGB_WHITE, n, 1'b1, 1'($urandom));
      6: write_regs(17'(lo), 17'(hi), c_lo, c_hi, 24'($urandom),
                    w == NUM_STOPS ? 4'hF : 4'(w), 1'b1, 1'b0);
      default: write_regs(17'(lo), 17'(hi), c_lo, c_hi, 24'($urandom), n, 1'($urandom),
                          1'($urandom));
    endcase
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i < POOL_SIZE / 2 && range_hi >= range_lo)
        key_pool[i] = 17'(int'(range_lo) + $urandom_range(0, int'(range_hi) - int'(range_lo)));
      else key_pool[i] = 17'($urandom);
    end
  endtask

  function automatic logic [16:0] pick_index();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r == 4) begin
      case ($urandom_range(0, 5))
        0: return range_lo;
        1: return range_hi;
        2: return range_lo - 17'sd1;
        3: return range_hi + 17'sd1;
        4: return 17'h10000;
        default: return 17'h0FFFF;
      endcase
    end
    if (r < 8 && range_hi > range_lo)
      return 17'(int'(range_lo) + $urandom_range(0, int'(range_hi) - int'(range_lo)));
    return 17'($urandom);
  endfunction

  function automatic lut_cmd_t random_cmd();
    lut_cmd_t c;
    int r;
    c.index = pick_index();
    c.addr = 10'($urandom);
    c.frac = 16'($urandom);
    c.rgb = 24'($urandom);
    r = $urandom_range(0, 99);
    if (r < 55) begin
      c.mode = MODE_LOOKUP;
      // a lookup must not land on a stop or gamma entry that was never written
      for (int t = 0; t < 20; t++) begin
        needs_fill = 1'b0;
        void'(map_index(longint'(c.index)));
        if (!needs_fill) return c;
        c.index = pick_index();
      end
      c.mode = fill_gamma ? MODE_GAMMA : MODE_STOP;
      c.addr = 10'(fill_addr);
      c.frac = 16'($urandom_range(1, 65535));
    end else if (r < 65) begin
      c.mode = MODE_STOP;
      if ($urandom_range(0, 5) != 0) c.addr = 10'($urandom_range(0, NUM_STOPS - 1));
      if ($urandom_range(0, 15) == 0) c.frac = 16'h0;
    end else if (r < 77) c.mode = MODE_OVR_SET;
    else if (r < 85) c.mode = MODE_OVR_DEL;
    else if (r < 97) c.mode = MODE_GAMMA;
    else c.mode = 3'($urandom_range(MODE_SPARE, MODE_TOP));
    return c;
  endfunction

  initial begin
    pixel_t none;
    none = '0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= REG_START;
    cfg_data_i <= '0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= MODE_LOOKUP;
    in_ch.index <= '0;
    in_ch.table_address <= '0;
    in_ch.fraction <= '0;
    in_ch.color_red <= '0;
    in_ch.color_green <= '0;
    in_ch.color_blue <= '0;
    for (int i = 0; i < NUM_OVR; i++) pin_live[i] = 1'b0;
    range_lo = 0;
    range_hi = 65535;
    colour_lo = 24'h0;
    colour_hi = RGB_WHITE;
    tint = RGB_WHITE;
    stop_cnt = 0;
    gamma_en = 1'b0;
    marker_en = 1'b0;
    plan = '{
      // after reset: black to white over 0..65535
      row(MODE_LOOKUP, 0, 0, 0, 24'h0, 1, 24'h000000, ST_OK),
      row(MODE_LOOKUP, 65535, 1023, 65535, RGB_WHITE, 1, RGB_WHITE, ST_OK),
      row(MODE_LOOKUP, -65536, 0, 0, 24'h0, 1, 24'h000000, ST_OK),
      row(MODE_LOOKUP, 32768, 0, 0, 24'h0, 0, 24'h0, ST_OK),
      row(MODE_SPARE, 5, 3, 7, 24'h0, 1, 24'h0, ST_BADARG),
      row(MODE_TOP, -1, 1023, 65535, RGB_WHITE, 1, 24'h0, ST_BADARG),
      row(MODE_STOP, 0, NUM_STOPS, 100, 24'h112233, 1, 24'h0, ST_BADARG),
      row(MODE_STOP, 0, 0, 0, 24'h112233, 1, 24'h0, ST_BADARG),
      row(MODE_STOP, 0, 1023, 1, 24'h112233, 1, 24'h0, ST_BADARG),
      row(MODE_STOP, 0, 0, 16'h4000, RGB_RED, 1, 24'h0, ST_OK),
      row(MODE_STOP, 0, 1, 16'hC000, 24'h00FF00, 1, 24'h0, ST_OK),
      row(MODE_OVR_SET, 100, 0, 0, 24'h123456, 1, 24'h0, ST_OK),
      row(MODE_LOOKUP, 100, 0, 0, 24'h0, 1, 24'h123456, ST_OK),
      row(MODE_OVR_DEL, 100, 0, 0, 24'h0, 1, 24'h0, ST_OK),
      row(MODE_LOOKUP, 100, 0, 0, 24'h0, 0, 24'h0, ST_OK),
      // removing a key that is not there is harmless
      row(MODE_OVR_DEL, 100, 0, 0, 24'h0, 1, 24'h0, ST_OK),
      row(MODE_GAMMA, 0, 0, 0, 24'h0, 1, 24'h0, ST_OK),
      row(MODE_GAMMA, 0, 1023, 65535, 24'h0, 1, 24'h0, ST_OK),
      row(MODE_OVR_SET, -65536, 0, 0, 24'hFEDCBA, 1, 24'h0, ST_OK),
      row(MODE_LOOKUP, 1, 0, 0, 24'h0, 0, 24'h0, ST_OK)
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (plan[i]) push_item(plan[i].cmd, plan[i].typed, plan[i].want);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      calm = (ph == NUM_PHASES - 1);
      configure(ph);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (ph == 3 && i == 40) hold_now = 1'b1;
        push_item(random_cmd(), 1'b0, none);
      end
    end
    wait_drained();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
